FILE: hw/rtl/pfcc_pkg.sv
package pfcc_pkg;

  localparam int NUM_CH = 4;
  localparam int WORD_W = 32;

  typedef struct packed {
    logic [4:0] dst_len;
    logic [4:0] dst_shift;
    logic [4:0] src_len;
    logic [4:0] src_shift;
  } layout_t;

  typedef enum logic [2:0] {
    REG_RED_LAYOUT   = 3'd0,
    REG_GREEN_LAYOUT = 3'd1,
    REG_BLUE_LAYOUT  = 3'd2,
    REG_ALPHA_LAYOUT = 3'd3,
    REG_DST_BYTES    = 3'd4
  } reg_index_t;

  localparam logic [19:0] RED_LAYOUT_RESET   = 20'd278800;
  localparam logic [19:0] GREEN_LAYOUT_RESET = 20'd270600;
  localparam logic [19:0] BLUE_LAYOUT_RESET  = 20'd262400;
  localparam logic [19:0] ALPHA_LAYOUT_RESET = 20'd287000;
  localparam logic [2:0]  DST_BYTES_RESET    = 3'd4;

  function automatic logic [WORD_W-1:0] byte_mask(input logic [2:0] nbytes);
    logic [WORD_W-1:0] m;
    case (nbytes)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

endpackage

FILE: hw/rtl/pixel_format_channel_converter_core.sv
// Converts one packed 32-bit source pixel per clock into a packed destination pixel.
// A request is taken whenever start is high and busy is low; busy is high only while
// rst is asserted, so a new pixel can follow in every cycle. Each result appears on
// dst_word for one cycle with done high. The pipeline performs field extraction, the
// rescale multiply, the per-channel rescale divider, which resolves four quotient bits
// per pipeline stage, then destination shift and the final sum and mask.
// Results cannot be held off, so the receiver must take every done cycle. Layout and
// dst_bytes registers are written through the cfg port and must only change while no
// pixel is in flight.
module pixel_format_channel_converter_core #(
  parameter int MAX_CHANNEL_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] src_word,
  output logic        done,
  output logic [31:0] dst_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  localparam int CW      = MAX_CHANNEL_BITS;
  localparam int LW      = $clog2(CW + 1);
  localparam int PW      = 2 * CW;
  localparam int STEPS   = 4;
  localparam int NDIV    = (CW + STEPS - 1) / STEPS;
  localparam int LATENCY = NDIV + 4;
  localparam int NC      = pfcc_pkg::NUM_CH;

  // configuration
  pfcc_pkg::layout_t cfg_layout [NC];
  logic [2:0]        cfg_dst_bytes;

  assign busy      = rst;
  assign cfg_ready = ~rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_layout[0] <= pfcc_pkg::layout_t'(pfcc_pkg::RED_LAYOUT_RESET);
      cfg_layout[1] <= pfcc_pkg::layout_t'(pfcc_pkg::GREEN_LAYOUT_RESET);
      cfg_layout[2] <= pfcc_pkg::layout_t'(pfcc_pkg::BLUE_LAYOUT_RESET);
      cfg_layout[3] <= pfcc_pkg::layout_t'(pfcc_pkg::ALPHA_LAYOUT_RESET);
      cfg_dst_bytes <= pfcc_pkg::DST_BYTES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (pfcc_pkg::reg_index_t'(cfg_index))
        pfcc_pkg::REG_RED_LAYOUT:   cfg_layout[0] <= pfcc_pkg::layout_t'(cfg_data);
        pfcc_pkg::REG_GREEN_LAYOUT: cfg_layout[1] <= pfcc_pkg::layout_t'(cfg_data);
        pfcc_pkg::REG_BLUE_LAYOUT:  cfg_layout[2] <= pfcc_pkg::layout_t'(cfg_data);
        pfcc_pkg::REG_ALPHA_LAYOUT: cfg_layout[3] <= pfcc_pkg::layout_t'(cfg_data);
        pfcc_pkg::REG_DST_BYTES:    cfg_dst_bytes <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  logic accept;
  assign accept = start && !busy;

  // stage 1: field extract, channel maxima
  logic          s1_vld;
  logic [CW-1:0] s1_v    [NC];
  logic [CW-1:0] s1_smax [NC];
  logic [CW-1:0] s1_dmax [NC];

  logic [CW-1:0] s1_v_next    [NC];
  logic [CW-1:0] s1_smax_next [NC];
  logic [CW-1:0] s1_dmax_next [NC];

  always_comb begin : extract
    logic [LW-1:0] s_len;
    logic [LW-1:0] d_len;
    logic [CW:0]   smax_w;
    logic [CW:0]   dmax_w;
    logic [31:0]   shifted;
    for (int c = 0; c < NC; c++) begin
      s_len = (cfg_layout[c].src_len > 5'(CW)) ? LW'(CW) : LW'(cfg_layout[c].src_len);
      d_len = (cfg_layout[c].dst_len > 5'(CW)) ? LW'(CW) : LW'(cfg_layout[c].dst_len);
      smax_w = ((CW+1)'(1) << s_len) - (CW+1)'(1);
      dmax_w = ((CW+1)'(1) << d_len) - (CW+1)'(1);
      shifted = src_word >> cfg_layout[c].src_shift;
      s1_v_next[c]    = shifted[CW-1:0] & smax_w[CW-1:0];
      // empty source field: value is zero, divisor forced to one
      s1_smax_next[c] = (s_len == '0) ? CW'(1) : smax_w[CW-1:0];
      s1_dmax_next[c] = dmax_w[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_v    <= s1_v_next;
    s1_smax <= s1_smax_next;
    s1_dmax <= s1_dmax_next;
  end

  // stage 2: v * dmax
  logic          s2_vld;
  logic [PW-1:0] s2_prod [NC];
  logic [CW-1:0] s2_smax [NC];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NC; c++) begin
      s2_prod[c] <= PW'(s1_v[c]) * PW'(s1_dmax[c]);
      s2_smax[c] <= s1_smax[c];
    end
  end

  // divider stages: restoring division by smax, STEPS quotient bits per stage
  logic          dv_vld [NDIV];
  logic [CW-1:0] dv_rem [NDIV][NC];
  logic [CW-1:0] dv_num [NDIV][NC];
  logic [CW-1:0] dv_q   [NDIV][NC];
  logic [CW-1:0] dv_div [NDIV][NC];

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    logic          vld_i;
    logic [CW-1:0] rem_i [NC];
    logic [CW-1:0] num_i [NC];
    logic [CW-1:0] q_i   [NC];
    logic [CW-1:0] div_i [NC];
    logic [CW-1:0] rem_o [NC];
    logic [CW-1:0] num_o [NC];
    logic [CW-1:0] q_o   [NC];

    if (k == 0) begin : g_first
      always_comb begin
        vld_i = s2_vld;
        for (int c = 0; c < NC; c++) begin
          rem_i[c] = s2_prod[c][PW-1:CW];
          num_i[c] = s2_prod[c][CW-1:0];
          q_i[c]   = '0;
          div_i[c] = s2_smax[c];
        end
      end
    end else begin : g_next
      always_comb begin
        vld_i = dv_vld[k-1];
        rem_i = dv_rem[k-1];
        num_i = dv_num[k-1];
        q_i   = dv_q[k-1];
        div_i = dv_div[k-1];
      end
    end

    always_comb begin : steps
      logic [CW:0] t;
      logic        ge;
      rem_o = rem_i;
      num_o = num_i;
      q_o   = q_i;
      for (int c = 0; c < NC; c++) begin
        for (int j = 0; j < STEPS; j++) begin
          if (k * STEPS + j < CW) begin
            t  = {rem_o[c], num_o[c][CW-1]};
            ge = (t >= {1'b0, div_i[c]});
            if (ge) begin
              rem_o[c] = CW'(t - {1'b0, div_i[c]});
            end else begin
              rem_o[c] = t[CW-1:0];
            end
            num_o[c] = num_o[c] << 1;
            q_o[c]   = CW'({q_o[c], ge});
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[k] <= 1'b0;
      end else begin
        dv_vld[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      dv_rem[k] <= rem_o;
      dv_num[k] <= num_o;
      dv_q[k]   <= q_o;
      dv_div[k] <= div_i;
    end
  end

  // destination placement
  logic        sh_vld;
  logic [31:0] sh_val [NC];

  always_ff @(posedge clk) begin
    if (rst) begin
      sh_vld <= 1'b0;
    end else begin
      sh_vld <= dv_vld[NDIV-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NC; c++) begin
      sh_val[c] <= 32'(dv_q[NDIV-1][c]) << cfg_layout[c].dst_shift;
    end
  end

  // sum modulo 2^32 and byte mask
  logic [31:0] sum_next;
  assign sum_next = (sh_val[0] + sh_val[1] + sh_val[2] + sh_val[3])
                    & pfcc_pkg::byte_mask(cfg_dst_bytes);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sh_vld;
    end
  end

  always_ff @(posedge clk) begin
    dst_word <= sum_next;
  end

  // every result traces back to a matching earlier request
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result without matching request");

  // bytes above dst_bytes never reach the output
  a_byte_mask: assert property (@(posedge clk) disable iff (rst)
    done |-> ((dst_word & ~pfcc_pkg::byte_mask(cfg_dst_bytes)) == 32'h0))
    else $error("result has bytes above dst_bytes");

  // divider remainder stays below the divisor at the last stage
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    dv_vld[NDIV-1] |-> (dv_rem[NDIV-1][0] < dv_div[NDIV-1][0]) &&
                       (dv_rem[NDIV-1][1] < dv_div[NDIV-1][1]) &&
                       (dv_rem[NDIV-1][2] < dv_div[NDIV-1][2]) &&
                       (dv_rem[NDIV-1][3] < dv_div[NDIV-1][3]))
    else $error("divider remainder out of range");

  // a request taken now is in the first stage next cycle
  a_stage_entry: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_vld)
    else $error("request lost at pipeline entry");

endmodule
